// ===== rtl/sbds_pkg.sv =====
// Shared types and codes for the two-stack word buffer.
package sbds_pkg;

  // Default number of words in the shared store
  localparam int unsigned DefaultDepth = 16;

  // Request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_PUSH_A = 3'd0,
    REQ_PUSH_B = 3'd1,
    REQ_POP_A  = 3'd2,
    REQ_POP_B  = 3'd3,
    REQ_LIST_A = 3'd4,
    REQ_LIST_B = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_POP_A,
    OP_POP_B,
    OP_LIST_A,
    OP_LIST_B,
    OP_STEP
  } dp_op_e;

  // Controller to datapath commands
  typedef struct packed {
    dp_op_e  op;
    logic    emit_status;
    status_e status;
    logic    emit_read;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic a_empty;
    logic b_empty;
    logic out_taken;
    logic out_last;
  } stat_t;

endpackage

// ===== rtl/sbds_ctrl.sv =====
// Request sequencer: decodes each item and steps the datapath through its results.
module sbds_ctrl import sbds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Take a new item only while nothing is in flight
  assign in_stall_o = (state_q != S_IDLE);

  // Decode requests and sequence reads and results
  always_comb begin
    state_d           = state_q;
    cmd_o.op          = OP_NONE;
    cmd_o.emit_status = 1'b0;
    cmd_o.status      = ST_OK;
    cmd_o.emit_read   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_PUSH_A, REQ_PUSH_B: begin
              cmd_o.emit_status = 1'b1;
              state_d           = S_OUT;
              if (stat_i.full) begin
                cmd_o.status = ST_OVERFLOW;
              end else begin
                cmd_o.op = (req_type_i == REQ_PUSH_A) ? OP_PUSH_A : OP_PUSH_B;
              end
            end
            REQ_POP_A: begin
              if (stat_i.a_empty) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = ST_UNDERFLOW;
                state_d           = S_OUT;
              end else begin
                cmd_o.op = OP_POP_A;
                state_d  = S_READ;
              end
            end
            REQ_POP_B: begin
              if (stat_i.b_empty) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = ST_UNDERFLOW;
                state_d           = S_OUT;
              end else begin
                cmd_o.op = OP_POP_B;
                state_d  = S_READ;
              end
            end
            REQ_LIST_A: begin
              if (stat_i.a_empty) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = ST_EMPTY;
                state_d           = S_OUT;
              end else begin
                cmd_o.op = OP_LIST_A;
                state_d  = S_READ;
              end
            end
            REQ_LIST_B: begin
              if (stat_i.b_empty) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = ST_EMPTY;
                state_d           = S_OUT;
              end else begin
                cmd_o.op = OP_LIST_B;
                state_d  = S_READ;
              end
            end
            default: begin
              // unused codes: drop the item
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.emit_read = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_taken) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_STEP;
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sbds_dp.sv =====
// Datapath: shared word store, stack counters, list pointer and result register.
module sbds_dp import sbds_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic signed [31:0] push_value_i,
  input  logic               out_stall_i,
  output stat_t              stat_o,
  output logic               out_valid_o,
  output logic signed [31:0] data_word_o,
  output logic [1:0]         status_o,
  output logic               last_item_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthW  = CW'(DEPTH);
  localparam logic [AW-1:0] TopAddr = AW'(DEPTH - 1);

  logic [CW-1:0] count_a_q, count_a_d;
  logic [CW-1:0] count_b_q, count_b_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          list_up_q, list_up_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_q;
  logic               rd_last_q;

  logic          wr_en, rd_en, rd_last;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [CW:0]   total;
  logic [CW-1:0] a_dec, b_top_w, b_push_w;
  logic [AW-1:0] ptr_step;

  logic               out_valid_q;
  logic signed [31:0] out_data_q;
  status_e            out_status_q;
  logic               out_last_q;
  logic               out_taken;

  // Derive addresses from the counters
  assign total    = {1'b0, count_a_q} + {1'b0, count_b_q};
  assign a_dec    = count_a_q - CW'(1);
  assign b_top_w  = DepthW - count_b_q;
  assign b_push_w = DepthW - count_b_q - CW'(1);
  assign ptr_step = list_up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));

  // Execute the controller's operation
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    ptr_d     = ptr_q;
    list_up_d = list_up_q;
    wr_en     = 1'b0;
    wr_addr   = count_a_q[AW-1:0];
    rd_en     = 1'b0;
    rd_addr   = ptr_q;
    rd_last   = 1'b1;
    case (cmd_i.op)
      OP_PUSH_A: begin
        wr_en     = 1'b1;
        wr_addr   = count_a_q[AW-1:0];
        count_a_d = count_a_q + CW'(1);
      end
      OP_PUSH_B: begin
        wr_en     = 1'b1;
        wr_addr   = b_push_w[AW-1:0];
        count_b_d = count_b_q + CW'(1);
      end
      OP_POP_A: begin
        rd_en     = 1'b1;
        rd_addr   = a_dec[AW-1:0];
        count_a_d = a_dec;
      end
      OP_POP_B: begin
        rd_en     = 1'b1;
        rd_addr   = b_top_w[AW-1:0];
        count_b_d = count_b_q - CW'(1);
      end
      OP_LIST_A: begin
        rd_en     = 1'b1;
        rd_addr   = a_dec[AW-1:0];
        ptr_d     = a_dec[AW-1:0];
        list_up_d = 1'b0;
        rd_last   = (a_dec[AW-1:0] == '0);
      end
      OP_LIST_B: begin
        rd_en     = 1'b1;
        rd_addr   = b_top_w[AW-1:0];
        ptr_d     = b_top_w[AW-1:0];
        list_up_d = 1'b1;
        rd_last   = (b_top_w[AW-1:0] == TopAddr);
      end
      OP_STEP: begin
        rd_en   = 1'b1;
        rd_addr = ptr_step;
        ptr_d   = ptr_step;
        rd_last = list_up_q ? (ptr_step == TopAddr) : (ptr_step == '0);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Hold counters and list pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
      ptr_q     <= '0;
      list_up_q <= 1'b0;
    end else begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      ptr_q     <= ptr_d;
      list_up_q <= list_up_d;
    end
  end

  // Word store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_last_q <= rd_last;
    end
  end

  // Result register: load on emit, drop once taken
  assign out_taken = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_read) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_data_q   <= '0;
      out_status_q <= cmd_i.status;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_read) begin
      out_data_q   <= rd_data_q;
      out_status_q <= ST_OK;
      out_last_q   <= rd_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_word_o = out_data_q;
  assign status_o    = out_status_q;
  assign last_item_o = out_last_q;

  assign stat_o.full      = (total >= {1'b0, DepthW});
  assign stat_o.a_empty   = (count_a_q == '0);
  assign stat_o.b_empty   = (count_b_q == '0);
  assign stat_o.out_taken = out_taken;
  assign stat_o.out_last  = out_last_q;

endmodule

// ===== rtl/shared_buffer_dual_stack.sv =====
// Two stacks sharing one word store: stack A grows up, stack B grows down.
// Push and error results appear the cycle after the item is accepted; a popped or first
// listed word passes through the registered store read and then the result register.
// Each further listed word is read from the store once the previous one is taken.
// Throughput: one item at a time; a new item is taken the cycle after its last result leaves.
// Reset clears both stack counters, the list pointer and the result valid flag; store contents stay undefined.
module shared_buffer_dual_stack import sbds_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] data_word_o,
  output logic [1:0]         status_o,
  output logic               last_item_o
);

  cmd_t  cmd;
  stat_t stat;

  sbds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbds_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_value_i (push_value_i),
    .out_stall_i  (out_stall_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .data_word_o  (data_word_o),
    .status_o     (status_o),
    .last_item_o  (last_item_o)
  );

  // Input side opens only once the result register has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // Error results are single, final and carry no word (ST_OK push results are not checked here)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_item_o && (data_word_o == '0))
    else $error("error result not final or carries data");

  // A result that is not final is followed by more results before new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_item_o |=> in_stall_o)
    else $error("input opened in the middle of a list");

endmodule
